// ===== hw/rtl/pntt_pkg.sv =====
// ---------------------------------------------------------------------------
// pntt_pkg
// Shared constants and types for the PWM period/duty to timer tick converter.
// ---------------------------------------------------------------------------
package pntt_pkg;

  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned TAG_W      = 72;

  localparam logic [31:0] NS_PER_SECOND = 32'd1000000000;
  localparam logic [31:0] FAST_CLOCK_HZ = 32'd168000000;
  localparam logic [31:0] SLOW_CLOCK_HZ = 32'd84000000;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PERIOD = 2'd1;
  localparam logic [1:0] ST_BAD_TIMER  = 2'd2;

  localparam logic [0:0] CFG_TIMER_SELECT = 1'd0;
  localparam logic [0:0] CFG_PRESCALER    = 1'd1;

  typedef struct packed {
    logic [1:0] status;
    logic       start;
    logic       high;
  } meta_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    meta_t       meta;
    logic [3:0]  pad;
  } tag_t;

endpackage

// ===== hw/rtl/pntt_div.sv =====
// ---------------------------------------------------------------------------
// pntt_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// ---------------------------------------------------------------------------
module pntt_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pntt_pkg::DIVIDEND_W-1:0]  in_dividend,
  input  logic [pntt_pkg::DIVISOR_W-1:0]   in_divisor,
  input  logic [pntt_pkg::TAG_W-1:0]       in_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pntt_pkg::DIVIDEND_W-1:0]  out_quotient,
  output logic [pntt_pkg::TAG_W-1:0]       out_tag
);
  import pntt_pkg::*;

  localparam int unsigned N = DIVIDEND_W;

  logic [N:0]              v_r;
  logic [N:0]              rdy;
  logic [DIVIDEND_W-1:0]   n_r [0:N];
  logic [DIVISOR_W-1:0]    rem_r [0:N];
  logic [DIVISOR_W-1:0]    d_r [0:N];
  logic [TAG_W-1:0]        tag_r [0:N];

  assign rdy[N]   = !v_r[N] || out_ready;
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      n_r[0]   <= in_dividend;
      rem_r[0] <= '0;
      d_r[0]   <= in_divisor;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [DIVISOR_W:0]   sh;
    logic                 ge;
    logic [DIVISOR_W:0]   diff;
    logic [DIVISOR_W-1:0] rem_nxt;

    assign rdy[s-1] = !v_r[s-1] || rdy[s];
    assign sh       = {rem_r[s-1], n_r[s-1][DIVIDEND_W-1]};
    assign ge       = sh >= {1'b0, d_r[s-1]};
    assign diff     = sh - {1'b0, d_r[s-1]};
    assign rem_nxt  = ge ? diff[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_r[s-1];
      end
      if (rdy[s]) begin
        n_r[s]   <= {n_r[s-1][DIVIDEND_W-2:0], ge};
        rem_r[s] <= rem_nxt;
        d_r[s]   <= d_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign out_valid    = v_r[N];
  assign out_quotient = n_r[N];
  assign out_tag      = tag_r[N];

endmodule

// ===== hw/rtl/pntt_mul.sv =====
// ---------------------------------------------------------------------------
// pntt_mul
// Registered 32x32 multiplier stage with side tag.
// ---------------------------------------------------------------------------
module pntt_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 in_a,
  input  logic [31:0]                 in_b,
  input  logic [pntt_pkg::TAG_W-1:0]  in_tag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_product,
  output logic [pntt_pkg::TAG_W-1:0]  out_tag
);
  import pntt_pkg::*;

  logic              v_r;
  logic [63:0]       p_r;
  logic [TAG_W-1:0]  tag_r;

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready) begin
      p_r   <= {32'd0, in_a} * {32'd0, in_b};
      tag_r <= in_tag;
    end
  end

  assign out_valid   = v_r;
  assign out_product = p_r;
  assign out_tag     = tag_r;

endmodule

// ===== hw/rtl/pwm_ns_to_timer_ticks.sv =====
// ---------------------------------------------------------------------------
// pwm_ns_to_timer_ticks
// Converts a PWM period and duty in ns to timer reload and compare values.
// ---------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with period, duty, enable and polarity;
// results leave on out_valid/out_ready with status, start flag, reload,
// compare and output level. Configuration (timer select, prescaler) must be
// written on cfg_we/cfg_index/cfg_data only while no request is in flight;
// the block itself does not enforce this. The datapath is a chain of
// bit-serial pipelined dividers: frequency and tick rate in parallel
// (65 stages), ticks (65 stages), one multiplier stage, then the compare
// division (65 stages). One request is taken every cycle unless stalled.
// Each stage has its own ready, so bubbles fill while the receiver stalls,
// and a stalled stage holds its request without loss or repeat.
// Synchronous reset empties the pipeline and clears both registers to 0.
// ---------------------------------------------------------------------------
module pwm_ns_to_timer_ticks (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_period_ns,
  input  logic [31:0] in_duty_ns,
  input  logic        in_enable,
  input  logic        in_polarity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_start_res,
  output logic [31:0] out_reload_value,
  output logic [31:0] out_compare_value,
  output logic        out_active_high
);
  import pntt_pkg::*;

  logic [3:0]  timer_select_r;
  logic [15:0] prescaler_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_select_r <= '0;
      prescaler_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_SELECT: timer_select_r <= cfg_data[3:0];
        CFG_PRESCALER:    prescaler_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request classification
  logic        bad_timer;
  logic        fast_clk;
  logic [31:0] timer_hz;
  meta_t       meta_in;
  tag_t        tag_a;

  assign bad_timer = timer_select_r > 4'd13 || timer_select_r == 4'd5 ||
                     timer_select_r == 4'd6;
  assign fast_clk  = timer_select_r == 4'd0 ||
                     (timer_select_r >= 4'd7 && timer_select_r <= 4'd10);
  assign timer_hz  = fast_clk ? FAST_CLOCK_HZ : SLOW_CLOCK_HZ;

  always_comb begin
    meta_in = '0;
    if (bad_timer) begin
      meta_in.status = ST_BAD_TIMER;
    end else if (in_period_ns > NS_PER_SECOND) begin
      meta_in.status = ST_BAD_PERIOD;
    end else if (in_enable) begin
      if (in_period_ns == 32'd0) begin
        meta_in.status = ST_BAD_PERIOD;
      end else begin
        meta_in.start = 1'b1;
        meta_in.high  = !in_polarity;
      end
    end
  end

  assign tag_a = '{a: in_duty_ns, b: in_period_ns, meta: meta_in, pad: 4'd0};

  // freq = 1e9 / period, rate = clk / (prescaler + 1)
  logic                  a_valid, a_rate_valid, a_rate_ready, a_freq_ready;
  logic [DIVIDEND_W-1:0] freq_q, rate_q;
  logic [TAG_W-1:0]      a_tag;
  logic                  b_ready;
  logic [16:0]           psc_p1;

  assign psc_p1   = {1'b0, prescaler_r} + 17'd1;
  assign in_ready = a_freq_ready && a_rate_ready;

  pntt_div u_div_freq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(a_freq_ready),
    .in_dividend({32'd0, NS_PER_SECOND}), .in_divisor(in_period_ns),
    .in_tag(tag_a),
    .out_valid(a_valid), .out_ready(b_ready),
    .out_quotient(freq_q), .out_tag(a_tag)
  );

  pntt_div u_div_rate (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(a_rate_ready),
    .in_dividend({32'd0, timer_hz}), .in_divisor({15'd0, psc_p1}),
    .in_tag(tag_a),
    .out_valid(a_rate_valid), .out_ready(b_ready),
    .out_quotient(rate_q), .out_tag()
  );

  // ticks = rate / freq
  logic                  b_valid, m_ready;
  logic [DIVIDEND_W-1:0] ticks_q;
  logic [TAG_W-1:0]      b_tag;
  tag_t                  b_tag_s, m_tag_in;

  pntt_div u_div_ticks (
    .clk(clk), .rst_n(rst_n),
    .in_valid(a_valid && a_rate_valid),
    .in_ready(b_ready),
    .in_dividend(rate_q), .in_divisor(freq_q[31:0]),
    .in_tag(a_tag),
    .out_valid(b_valid), .out_ready(m_ready),
    .out_quotient(ticks_q), .out_tag(b_tag)
  );

  assign b_tag_s  = tag_t'(b_tag);
  assign m_tag_in = '{a: ticks_q[31:0], b: b_tag_s.b, meta: b_tag_s.meta, pad: 4'd0};

  // product = duty * ticks
  logic             m_valid, c_ready;
  logic [63:0]      product;
  logic [TAG_W-1:0] m_tag;
  tag_t             m_tag_s;

  pntt_mul u_mul (
    .clk(clk), .rst_n(rst_n),
    .in_valid(b_valid), .in_ready(m_ready),
    .in_a(b_tag_s.a), .in_b(ticks_q[31:0]),
    .in_tag(m_tag_in),
    .out_valid(m_valid), .out_ready(c_ready),
    .out_product(product), .out_tag(m_tag)
  );

  assign m_tag_s = tag_t'(m_tag);

  // compare = product / period
  logic                  c_valid;
  logic [DIVIDEND_W-1:0] cmp_q;
  logic [TAG_W-1:0]      c_tag;
  tag_t                  c_tag_s;
  logic                  ok;

  pntt_div u_div_cmp (
    .clk(clk), .rst_n(rst_n),
    .in_valid(m_valid), .in_ready(c_ready),
    .in_dividend(product), .in_divisor(m_tag_s.b),
    .in_tag(m_tag),
    .out_valid(c_valid), .out_ready(out_ready),
    .out_quotient(cmp_q), .out_tag(c_tag)
  );

  assign c_tag_s = tag_t'(c_tag);
  assign ok      = c_tag_s.meta.status == ST_OK && c_tag_s.meta.start;

  assign out_valid         = c_valid;
  assign out_status        = c_tag_s.meta.status;
  assign out_start_res     = ok;
  assign out_reload_value  = ok ? c_tag_s.a - 32'd1 : 32'd0;
  assign out_compare_value = !ok ? 32'd0 :
                             (cmp_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : cmp_q[31:0];
  assign out_active_high   = ok && c_tag_s.meta.high;

endmodule
